/* hdl/rpsc_pkg.sv */
// ----------------------------------------------------------------------------
// rpsc_pkg
// Shared types and constants for the radar pulse sweep conditioner: the
// payload structs of both channels, the configuration struct and the
// register index codes.
// ----------------------------------------------------------------------------
package rpsc_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register index codes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_OFS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SWEEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_EN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_BACK_EN = 3'd4;

  // Nanoseconds per second, wide enough to add to a 30-bit nanosecond field
  localparam logic [30:0] NS_PER_SEC = 31'd1_000_000_000;

  typedef struct packed {
    logic        heading_enable;
    logic [15:0] heading_offset;
    logic        zero_sweep_enable;
    logic        delay_enable;
    logic        drop_backwards_enable;
  } rpsc_cfg_t;

  typedef struct packed {
    logic [15:0] volume_number;
    logic [15:0] sweep_number;
    logic [15:0] azimuth_angle;
    logic        is_sector_scan;
    logic [31:0] time_seconds;
    logic [29:0] time_nanoseconds;
  } rpsc_in_t;

  typedef struct packed {
    logic [15:0] sweep_number_out;
    logic [15:0] azimuth_out;
    logic        keep_pulse;
  } rpsc_out_t;

endpackage

/* hdl/rpsc_sweep.sv */
// ----------------------------------------------------------------------------
// rpsc_sweep
// Volume tracking, sweep rebasing and the sector-scan sweep change delay.
// State advances on each transfer through the processing stage.
// ----------------------------------------------------------------------------
module rpsc_sweep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  rpsc_pkg::rpsc_cfg_t cfg,
  input  logic [15:0]         volume_number,
  input  logic [15:0]         sweep_number,
  input  logic [15:0]         azimuth,
  input  logic                is_sector_scan,
  output logic [15:0]         sweep_out
);
  import rpsc_pkg::*;

  logic        vol_valid_r, vol_valid_nxt;
  logic [15:0] last_vol_r, last_vol_nxt;
  logic [15:0] first_sweep_r, first_sweep_nxt;
  logic        started_r, started_nxt;
  logic        pending_r, pending_nxt;
  logic [15:0] held_sweep_r, held_sweep_nxt;
  logic [15:0] held_az_r, held_az_nxt;
  logic        dir_neg_r, dir_neg_nxt;

  logic        new_vol;
  logic [15:0] first_eff;
  logic [15:0] rebased;
  logic [15:0] az_step;
  logic        step_neg;

  // New volume detection and rebase
  always_comb begin
    new_vol         = !vol_valid_r || (volume_number != last_vol_r);
    first_eff       = new_vol ? sweep_number : first_sweep_r;
    rebased         = cfg.zero_sweep_enable ? (sweep_number - first_eff) : sweep_number;
    vol_valid_nxt   = 1'b1;
    last_vol_nxt    = volume_number;
    first_sweep_nxt = first_eff;
  end

  // Signed azimuth step; a half-turn step counts as negative
  assign az_step  = azimuth - held_az_r;
  assign step_neg = az_step[15];

  // Sector-scan delay: hold the old sweep until the antenna turns around
  always_comb begin
    started_nxt    = started_r;
    pending_nxt    = pending_r;
    held_sweep_nxt = held_sweep_r;
    held_az_nxt    = held_az_r;
    dir_neg_nxt    = dir_neg_r;
    sweep_out      = rebased;
    if (cfg.delay_enable && is_sector_scan) begin
      priority if (!started_r) begin
        started_nxt    = 1'b1;
        pending_nxt    = 1'b0;
        held_sweep_nxt = rebased;
        held_az_nxt    = azimuth;
      end else if (rebased == held_sweep_r) begin
        pending_nxt = 1'b0;
        held_az_nxt = azimuth;
      end else if (azimuth == held_az_r) begin
        sweep_out = held_sweep_r;
      end else begin
        held_az_nxt = azimuth;
        priority if (!pending_r) begin
          dir_neg_nxt = step_neg;
          pending_nxt = 1'b1;
          sweep_out   = held_sweep_r;
        end else if (step_neg != dir_neg_r) begin
          pending_nxt    = 1'b0;
          held_sweep_nxt = rebased;
        end else begin
          sweep_out = held_sweep_r;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_valid_r   <= 1'b0;
      last_vol_r    <= '0;
      first_sweep_r <= '0;
      started_r     <= 1'b0;
      pending_r     <= 1'b0;
      held_sweep_r  <= '0;
      held_az_r     <= '0;
      dir_neg_r     <= 1'b0;
    end else if (adv) begin
      vol_valid_r   <= vol_valid_nxt;
      last_vol_r    <= last_vol_nxt;
      first_sweep_r <= first_sweep_nxt;
      started_r     <= started_nxt;
      pending_r     <= pending_nxt;
      held_sweep_r  <= held_sweep_nxt;
      held_az_r     <= held_az_nxt;
      dir_neg_r     <= dir_neg_nxt;
    end
  end

  // A pending change only exists once the delay has started
  a_pending_started: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> started_r)
    else $error("sweep change pending before delay started");

  // Any transfer marks a volume as seen
  a_vol_seen: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> vol_valid_r)
    else $error("volume not recorded after transfer");

  // With the delay inactive the held sweep holds
  a_delay_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !(cfg.delay_enable && is_sector_scan)) |=> $stable(held_sweep_r))
    else $error("held sweep changed with delay inactive");

endmodule

/* hdl/rpsc_time.sv */
// ----------------------------------------------------------------------------
// rpsc_time
// Pulse time advance check. Compares seconds and nanoseconds as one exact
// time value without a multiplier: seconds more than one apart decide
// alone, otherwise the nanoseconds are compared with a one-second bias.
// ----------------------------------------------------------------------------
module rpsc_time (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        enable,
  input  logic [31:0] time_seconds,
  input  logic [29:0] time_nanoseconds,
  output logic        keep_pulse
);
  import rpsc_pkg::*;

  logic        last_valid_r;
  logic [31:0] last_sec_r;
  logic [29:0] last_ns_r;

  logic [32:0] sec_diff_fwd;
  logic [32:0] sec_diff_bwd;
  logic        sec_eq;
  logic        sec_gt;
  logic        sec_plus1;
  logic        sec_minus1;
  logic [30:0] ns_cur;
  logic [30:0] ns_last;
  logic        later;
  logic        record;

  // Seconds relation
  assign sec_diff_fwd = {1'b0, time_seconds} - {1'b0, last_sec_r};
  assign sec_diff_bwd = {1'b0, last_sec_r} - {1'b0, time_seconds};
  assign sec_eq       = (time_seconds == last_sec_r);
  assign sec_gt       = (time_seconds > last_sec_r);
  assign sec_plus1    = (sec_diff_fwd == 33'd1);
  assign sec_minus1   = (sec_diff_bwd == 33'd1);
  assign ns_cur       = {1'b0, time_nanoseconds};
  assign ns_last      = {1'b0, last_ns_r};

  // Strictly later test on seconds*1e9 + nanoseconds
  always_comb begin
    priority if (sec_eq)     later = ns_cur > ns_last;
    else if (sec_plus1)      later = (ns_cur + NS_PER_SEC) > ns_last;
    else if (sec_minus1)     later = ns_cur > (ns_last + NS_PER_SEC);
    else                     later = sec_gt;
  end

  assign keep_pulse = !enable || !last_valid_r || later;
  assign record     = adv && enable && keep_pulse;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_valid_r <= 1'b0;
      last_sec_r   <= '0;
      last_ns_r    <= '0;
    end else if (record) begin
      last_valid_r <= 1'b1;
      last_sec_r   <= time_seconds;
      last_ns_r    <= time_nanoseconds;
    end
  end

  // A dropped pulse leaves the record alone
  a_drop_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !keep_pulse) |=> ($stable(last_sec_r) && $stable(last_ns_r)))
    else $error("time record changed on dropped pulse");

  // The first checked pulse is always kept
  a_first_kept: assert property (@(posedge clk) disable iff (!rst_n)
    !last_valid_r |-> keep_pulse)
    else $error("first checked pulse dropped");

  // A checked transfer always leaves a valid record
  a_record_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && enable) |=> last_valid_r)
    else $error("time record not valid after checked pulse");

endmodule

/* hdl/radar_pulse_sweep_conditioner.sv */
// ----------------------------------------------------------------------------
// radar_pulse_sweep_conditioner
// Takes one pulse header per transfer and returns one conditioned header:
// heading-corrected azimuth, rebased and sector-delayed sweep number, and a
// keep flag that clears, when enabled, if the pulse time does not advance. Headers enter
// an input register, pass one short stage of logic that also updates the
// volume, delay and time state, and land in the output register. One header
// is taken every cycle while the output side does not stall. Configuration
// registers are written through the plain cfg_ port; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module radar_pulse_sweep_conditioner (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  rpsc_pkg::rpsc_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output rpsc_pkg::rpsc_out_t                  out_data,
  input  logic                                 cfg_wr_en,
  input  logic [rpsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rpsc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import rpsc_pkg::*;

  rpsc_cfg_t   cfg_r;
  logic        s1_valid_r;
  rpsc_in_t    s1_data_r;
  logic        out_valid_r;
  rpsc_out_t   out_data_r;
  rpsc_out_t   out_data_nxt;

  logic        s1_adv;
  logic        in_xfer;
  logic [15:0] az_corr;
  logic [15:0] sweep_res;
  logic        keep_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HEADING_EN:   cfg_r.heading_enable        <= cfg_wdata[0];
        CFG_HEADING_OFS:  cfg_r.heading_offset        <= cfg_wdata[15:0];
        CFG_ZERO_SWEEP:   cfg_r.zero_sweep_enable     <= cfg_wdata[0];
        CFG_DELAY_EN:     cfg_r.delay_enable          <= cfg_wdata[0];
        CFG_DROP_BACK_EN: cfg_r.drop_backwards_enable <= cfg_wdata[0];
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  // Handshake: the processing stage moves when the output register is free
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Heading correction, modulo a full turn
  assign az_corr = cfg_r.heading_enable ? (s1_data_r.azimuth_angle + cfg_r.heading_offset)
                                        : s1_data_r.azimuth_angle;

  rpsc_sweep u_sweep (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (s1_adv),
    .cfg            (cfg_r),
    .volume_number  (s1_data_r.volume_number),
    .sweep_number   (s1_data_r.sweep_number),
    .azimuth        (az_corr),
    .is_sector_scan (s1_data_r.is_sector_scan),
    .sweep_out      (sweep_res)
  );

  rpsc_time u_time (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (s1_adv),
    .enable           (cfg_r.drop_backwards_enable),
    .time_seconds     (s1_data_r.time_seconds),
    .time_nanoseconds (s1_data_r.time_nanoseconds),
    .keep_pulse       (keep_res)
  );

  always_comb begin
    out_data_nxt.sweep_number_out = sweep_res;
    out_data_nxt.azimuth_out      = az_corr;
    out_data_nxt.keep_pulse       = keep_res;
  end

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Input only stalls while the processing stage holds an item
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty stage");

  // Every stage advance produces a result next cycle
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("stage advanced without result");

  // An accepted item occupies the stage next cycle
  a_xfer_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted item lost");

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: radar_pulse_sweep_conditioner testbench
// Sends pulse headers through the valid/stall input channel and checks each
// conditioned header against an in-bench predictor. The predictor tracks
// heading correction, sweep rebasing per volume, the sector-scan hold of
// sweep changes, and the time-advance check. A short directed run covers
// the corner cases. Randomized scan-like sequences with some noise follow,
// under several register settings and sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpsc_pkg::*;

  localparam int unsigned          LIMIT_CYCLES  = 400000;
  localparam int unsigned          PHASES        = 8;
  localparam int unsigned          PHASE_ITEMS   = 66;
  localparam int unsigned          MAX_PRINTS    = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX   = 3'd7;

  // Predictor plus queue of conditioned headers still to come out
  class sweep_scoreboard;
    rpsc_cfg_t   cfg;
    rpsc_out_t   conditioned_q[$];
    int unsigned errors;
    bit          vol_seen;
    logic [15:0] prev_volume;
    logic [15:0] first_sweep;
    bit          hold_armed;
    bit          change_waiting;
    bit          turn_neg;
    logic [15:0] kept_sweep;
    logic [15:0] kept_azimuth;
    bit          time_seen;
    logic [31:0] mark_sec;
    logic [29:0] mark_ns;

    function new();
      cfg            = '0;
      errors         = 0;
      vol_seen       = 1'b0;
      prev_volume    = '0;
      first_sweep    = '0;
      hold_armed     = 1'b0;
      change_waiting = 1'b0;
      turn_neg       = 1'b0;
      kept_sweep     = '0;
      kept_azimuth   = '0;
      time_seen      = 1'b0;
      mark_sec       = '0;
      mark_ns        = '0;
    endfunction

    // Register write as the block sees it: masked to width, unknown index ignored
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_HEADING_EN:   cfg.heading_enable        = data[0];
        CFG_HEADING_OFS:  cfg.heading_offset        = data[15:0];
        CFG_ZERO_SWEEP:   cfg.zero_sweep_enable     = data[0];
        CFG_DELAY_EN:     cfg.delay_enable          = data[0];
        CFG_DROP_BACK_EN: cfg.drop_backwards_enable = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return conditioned_q.size();
    endfunction

    task report_mismatch(string what);
      if (errors < MAX_PRINTS) begin
        $display("ERROR @%0t: %s", $realtime, what);
      end
      errors++;
    endtask

    // Accepted header in: work out the conditioned header it must produce
    function void note_header(rpsc_in_t h);
      rpsc_out_t   e;
      logic [15:0] az;
      logic [15:0] sw;
      logic [15:0] step;
      logic [63:0] now_ns;
      logic [63:0] mark_total;
      bit          neg;
      az = h.azimuth_angle;
      if (cfg.heading_enable) az = az + cfg.heading_offset;
      sw = h.sweep_number;

      // volume tracking runs regardless of the enables
      if (!vol_seen || h.volume_number != prev_volume) begin
        first_sweep = sw;
        prev_volume = h.volume_number;
        vol_seen    = 1'b1;
      end
      if (cfg.zero_sweep_enable) sw = sw - first_sweep;

      // sector-scan hold of a sweep change until the antenna turns round
      if (cfg.delay_enable && h.is_sector_scan) begin
        if (!hold_armed) begin
          change_waiting = 1'b0;
          hold_armed     = 1'b1;
          kept_sweep     = sw;
          kept_azimuth   = az;
        end else if (sw == kept_sweep) begin
          change_waiting = 1'b0;
          kept_azimuth   = az;
        end else if (az == kept_azimuth) begin
          sw = kept_sweep;
        end else begin
          step         = az - kept_azimuth;
          neg          = step[15];  // half a turn counts as negative
          kept_azimuth = az;
          if (!change_waiting) begin
            turn_neg       = neg;
            change_waiting = 1'b1;
            sw             = kept_sweep;
          end else if (neg != turn_neg) begin
            change_waiting = 1'b0;
            kept_sweep     = sw;
          end else begin
            sw = kept_sweep;
          end
        end
      end

      // time must strictly advance; nanoseconds may exceed one second
      e.keep_pulse = 1'b1;
      if (cfg.drop_backwards_enable) begin
        now_ns     = {32'd0, h.time_seconds} * 64'd1_000_000_000 + {34'd0, h.time_nanoseconds};
        mark_total = {32'd0, mark_sec} * 64'd1_000_000_000 + {34'd0, mark_ns};
        if (time_seen && now_ns <= mark_total) begin
          e.keep_pulse = 1'b0;
        end else begin
          time_seen = 1'b1;
          mark_sec  = h.time_seconds;
          mark_ns   = h.time_nanoseconds;
        end
      end

      e.sweep_number_out = sw;
      e.azimuth_out      = az;
      conditioned_q.push_back(e);
    endfunction

    // Accepted result out: compare with the oldest outstanding header
    task check_header(rpsc_out_t got);
      rpsc_out_t want;
      if (conditioned_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result sweep %h az %h keep %b",
                                  got.sweep_number_out, got.azimuth_out, got.keep_pulse));
        return;
      end
      want = conditioned_q.pop_front();
      if (got.sweep_number_out !== want.sweep_number_out)
        report_mismatch($sformatf("sweep_number_out got %h want %h",
                                  got.sweep_number_out, want.sweep_number_out));
      if (got.azimuth_out !== want.azimuth_out)
        report_mismatch($sformatf("azimuth_out got %h want %h",
                                  got.azimuth_out, want.azimuth_out));
      if (got.keep_pulse !== want.keep_pulse)
        report_mismatch($sformatf("keep_pulse got %b want %b",
                                  got.keep_pulse, want.keep_pulse));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  rpsc_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  rpsc_out_t             out_data;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sweep_scoreboard sb;
  int unsigned     idle_pct;
  int unsigned     stall_pct;
  int unsigned     cycles = 0;

  // Scan generator state
  logic [15:0] scan_vol;
  logic [15:0] scan_sweep;
  logic [15:0] scan_az;
  logic [15:0] scan_step;
  logic [31:0] scan_sec;
  int unsigned scan_ns;
  int unsigned sector_pct;

  radar_pulse_sweep_conditioner DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Transfer monitor on both channels
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid && !in_stall) sb.note_header(in_data);
      if (out_valid && !out_stall) sb.check_header(out_data);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("radar_pulse_sweep_conditioner: mismatch");
      $finish;
    end
  end

  // One register write; caller lowers cfg_wr_en after the last one
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Write every register, junk in the unused upper bits, plus one stray index
  task automatic apply_config(rpsc_cfg_t c);
    logic [CFG_DATA_W-1:0] wd;
    wd = CFG_DATA_W'($urandom); wd[0] = c.heading_enable;
    write_reg(CFG_HEADING_EN, wd);
    write_reg(CFG_HEADING_OFS, c.heading_offset);
    wd = CFG_DATA_W'($urandom); wd[0] = c.zero_sweep_enable;
    write_reg(CFG_ZERO_SWEEP, wd);
    wd = CFG_DATA_W'($urandom); wd[0] = c.delay_enable;
    write_reg(CFG_DELAY_EN, wd);
    wd = CFG_DATA_W'($urandom); wd[0] = c.drop_backwards_enable;
    write_reg(CFG_DROP_BACK_EN, wd);
    write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_IDX_MAX)), CFG_DATA_W'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  // Present one header, hold it until the transfer, then maybe go idle
  task automatic send_header(rpsc_in_t h);
    in_valid <= 1'b1;
    in_data  <= h;
    do @(posedge clk); while (in_stall !== 1'b0);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_fields(logic [15:0] vol, logic [15:0] sweep, logic [15:0] az,
                             logic sector, logic [31:0] secs, logic [29:0] nanos);
    rpsc_in_t h;
    h.volume_number    = vol;
    h.sweep_number     = sweep;
    h.azimuth_angle    = az;
    h.is_sector_scan   = sector;
    h.time_seconds     = secs;
    h.time_nanoseconds = nanos;
    send_header(h);
  endtask

  // Sender holds off until every outstanding header has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic seed_scan();
    scan_vol   = 16'($urandom);
    scan_sweep = 16'($urandom);
    scan_az    = 16'($urandom);
    scan_step  = 16'($urandom_range(1, 300));
    scan_sec   = $urandom;
    scan_ns    = $urandom_range(0, 999_999_999);
  endtask

  // Next header of a sector/full scan; a few are pure noise
  task automatic make_header(output rpsc_in_t h);
    logic [15:0] step_now;
    int unsigned r;
    if ($urandom_range(99) < 8) begin
      h.volume_number    = 16'($urandom);
      h.sweep_number     = 16'($urandom);
      h.azimuth_angle    = 16'($urandom);
      h.is_sector_scan   = 1'($urandom);
      h.time_seconds     = $urandom;
      h.time_nanoseconds = 30'($urandom);
      return;
    end
    if ($urandom_range(99) < 4) begin
      scan_vol   = ($urandom_range(1) != 0) ? scan_vol + 16'd1 : 16'($urandom);
      scan_sweep = 16'($urandom);
    end
    if ($urandom_range(99) < 8) scan_sweep = scan_sweep + 16'd1;
    // antenna turnaround or a new rate
    if ($urandom_range(99) < 10) scan_step = -scan_step;
    if ($urandom_range(99) < 3) begin
      scan_step = 16'($urandom_range(1, 400));
      if ($urandom_range(1) != 0) scan_step = -scan_step;
    end
    r = $urandom_range(99);
    if (r < 5)      step_now = 16'd0;
    else if (r < 7) step_now = 16'h8000;
    else            step_now = scan_step;
    scan_az = scan_az + step_now;
    // time: mostly forward, sometimes repeated or backwards
    r = $urandom_range(99);
    if (r >= 10) begin
      scan_ns = scan_ns + $urandom_range(1, 600_000_000);
      if (scan_ns >= 1_000_000_000) begin
        scan_ns  = scan_ns - 1_000_000_000;
        scan_sec = scan_sec + 32'd1;
      end
    end else if (r >= 6) begin
      scan_sec = scan_sec - 32'($urandom_range(0, 2));
      scan_ns  = $urandom_range(0, 999_999_999);
    end
    h.volume_number  = scan_vol;
    h.sweep_number   = scan_sweep;
    h.azimuth_angle  = scan_az;
    h.is_sector_scan = ($urandom_range(99) < sector_pct);
    h.time_seconds   = scan_sec;
    if ($urandom_range(99) < 5)
      h.time_nanoseconds = 30'($urandom_range(1_000_000_000, 30'h3FFF_FFFF));
    else
      h.time_nanoseconds = 30'(scan_ns);
  endtask

  initial begin
    rpsc_cfg_t   c;
    rpsc_in_t    h;
    int unsigned idle_mode [4];
    int unsigned stall_mode[4];
    sb         = new();
    idle_mode  = '{0, 82, 0, 8};
    stall_mode = '{0, 0, 82, 8};
    idle_pct   = 0;
    stall_pct  = 0;
    sector_pct = 85;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes with everything bypassed
    send_fields(16'h0000, 16'h0000, 16'h0000, 1'b0, 32'h0000_0000, 30'd0);
    send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 30'd999_999_999);
    send_fields(16'hFFFF, 16'h1234, 16'h8000, 1'b1, 32'h0000_0000, 30'h3FFF_FFFF);
    drain();

    // Directed: all stages on, heading offset at its maximum
    c = '{heading_enable: 1'b1, heading_offset: 16'hFFFF, zero_sweep_enable: 1'b1,
          delay_enable: 1'b1, drop_backwards_enable: 1'b1};
    apply_config(c);
    send_fields(16'd5, 16'd10, 16'd100, 1'b1, 32'd10, 30'd0);  // new volume, first hold
    send_fields(16'd5, 16'd3, 16'd100, 1'b1, 32'd10, 30'd0);   // rebase wraps, no step, same time
    send_fields(16'd5, 16'd3, 16'd200, 1'b1, 32'd9, 30'd0);    // first step, time goes back
    send_fields(16'd5, 16'd3, 16'd300, 1'b1, 32'd11, 30'd0);   // same direction, still held
    send_fields(16'd5, 16'd3, 16'd250, 1'b1, 32'd12, 30'd0);   // turnaround completes change
    send_fields(16'd5, 16'd3, 16'd260, 1'b1, 32'd13, 30'd0);   // sweep equals held one
    send_fields(16'd5, 16'd4, 16'h8104, 1'b1, 32'd14, 30'd0);  // half-turn step is negative
    send_fields(16'd5, 16'd4, 16'h8110, 1'b1, 32'd15, 30'd0);  // positive step completes
    send_fields(16'd6, 16'd20, 16'd0, 1'b0, 32'd16, 30'd0);    // new volume, hold untouched
    send_fields(16'd6, 16'd21, 16'd0, 1'b1, 32'd20, 30'd0);
    send_fields(16'd6, 16'd21, 16'd5, 1'b1, 32'd19, 30'h3FFF_FFFF);     // ns above 1 s, later
    send_fields(16'd6, 16'd21, 16'd9, 1'b1, 32'd20, 30'd73_741_823);    // exactly equal time
    send_fields(16'd6, 16'd22, 16'd9, 1'b0, 32'hFFFF_FFFF, 30'd999_999_999);
    drain();

    // Randomized scan phases under varied settings and idling
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: c = '{1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1};
        1: c = '{1'b0, 16'h0000, 1'b0, 1'b0, 1'b0};
        2: c = '{1'b1, 16'h0000, 1'b1, 1'b1, 1'b0};
        default: begin
          c.heading_enable        = 1'($urandom);
          c.heading_offset        = 16'($urandom);
          c.zero_sweep_enable     = 1'($urandom);
          c.delay_enable          = ($urandom_range(99) < 75);
          c.drop_backwards_enable = 1'($urandom);
        end
      endcase
      apply_config(c);
      idle_pct   = idle_mode[ph % 4];
      stall_pct  = stall_mode[ph % 4];
      sector_pct = (ph == 5) ? 50 : 90;
      seed_scan();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        make_header(h);
        send_header(h);
      end
      drain();
    end

    // Wind down: let the pipe empty, then a short tail
    stall_pct = 0;
    idle_pct  = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("radar_pulse_sweep_conditioner: match");
    end else begin
      $display("radar_pulse_sweep_conditioner: mismatch");
    end
    $finish;
  end

endmodule
